FILE: sv/chained_hash_map_engine_assert.svh
// ----------------------------------------------------------------------------
// Chained hash map engine assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_MAP_ENGINE_ASSERT_SVH
`define CHAINED_HASH_MAP_ENGINE_ASSERT_SVH

// property that holds at every edge
`define CHM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define CHM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/chm_pkg.sv
// ----------------------------------------------------------------------------
// Chained hash map package
// Field widths, request and status codes, register indexes, defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package chm_pkg;

  // defaults for the top level parameters
  localparam int unsigned DEF_MAX_BUCKETS = 1024;
  localparam int unsigned DEF_NODE_COUNT  = 4096;
  localparam int unsigned DEF_KEY_BITS    = 32;
  localparam int unsigned DEF_VALUE_BITS  = 32;

  // fixed field widths
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned ELEM_W    = 13;
  localparam int unsigned BKT_W     = 11;
  localparam int unsigned INIT_W    = 11;
  localparam int unsigned RATIO_W   = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 12;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_PUT    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_GET    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

  // result status
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_ARG = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDEAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd3;

  // register reset values
  localparam logic [INIT_W-1:0]  INIT_RST  = 11'd5;
  localparam logic [RATIO_W-1:0] IDEAL_RST = 12'd48;
  localparam logic [RATIO_W-1:0] LOWER_RST = 12'd0;
  localparam logic [RATIO_W-1:0] UPPER_RST = 12'd240;

  // bucket count after clear, smallest rehash count, trial divisor range
  localparam int unsigned CLEAR_BUCKETS = 5;
  localparam int unsigned MIN_BUCKETS   = 5;
  localparam logic [5:0]  TRIAL_FIRST   = 6'd3;
  localparam logic [5:0]  TRIAL_LAST    = 6'd49;

endpackage

FILE: sv/chm_ram.sv
// ----------------------------------------------------------------------------
// Chained hash map RAM
// Simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: sv/chained_hash_map_engine.sv
// Get/put/remove hash the key to a bucket index and then walk that bucket's chain;
//   the bucket index comes from a shared restoring divider, one quotient bit per cycle.
// A rehash clears the MAX_BUCKETS heads of the target bank, runs a prime search over odd
//   trial divisors 3 to 49, and moves every stored node into the target bank. Clear sweeps both banks.
// One item at a time; a result waits in the output register while the next item is taken.
// Reset: asynchronous, active low; a head sweep of the same length as clear follows.
// ----------------------------------------------------------------------------
// Chained hash map engine
// Key-value store with separate chaining, a fixed node pool, and rehash on
// load thresholds. Bucket heads live in two banks; a rehash moves every node
// into the other bank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chained_hash_map_engine #(
  parameter int unsigned MAX_BUCKETS = chm_pkg::DEF_MAX_BUCKETS,
  parameter int unsigned NODE_COUNT  = chm_pkg::DEF_NODE_COUNT,
  parameter int unsigned KEY_BITS    = chm_pkg::DEF_KEY_BITS,
  parameter int unsigned VALUE_BITS  = chm_pkg::DEF_VALUE_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  // request item
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: key, value
  input  logic [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: req_type
  input  logic [chm_pkg::REQ_W-1:0] s_axis_tuser,
  // result item
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata: found, read_value, status, element_count, bucket_count
  output logic [((1+VALUE_BITS+chm_pkg::STAT_W+chm_pkg::ELEM_W+chm_pkg::BKT_W+7)/8)*8-1:0]
               m_axis_tdata,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [chm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [chm_pkg::CFG_DAT_W-1:0] cfg_data_i
);

`include "chained_hash_map_engine_assert.svh"

  // --------------------------------------------------------------------------
  // widths
  // --------------------------------------------------------------------------
  localparam int unsigned KW    = KEY_BITS;
  localparam int unsigned VW    = VALUE_BITS;
  localparam int unsigned NW    = $clog2(NODE_COUNT);        // node index
  localparam int unsigned LW    = $clog2(NODE_COUNT + 1);    // link, NODE_COUNT = empty
  localparam int unsigned CNT_W = $clog2(NODE_COUNT + 1);    // counts
  localparam int unsigned BAW   = $clog2(MAX_BUCKETS);       // bucket index
  localparam int unsigned BCW   = $clog2(MAX_BUCKETS + 1);   // bucket count
  localparam int unsigned HAW   = BAW + 1;                   // bank + index
  localparam int unsigned HEAD_DEPTH = 2 ** HAW;
  localparam int unsigned RW    = chm_pkg::RATIO_W;
  // divider width covers keys, scaled counts, bucket counts and ratios
  localparam int unsigned DW0   = (KW > CNT_W + 5) ? KW : CNT_W + 5;
  localparam int unsigned DW1   = (DW0 > BCW) ? DW0 : BCW;
  localparam int unsigned DW    = (DW1 > RW) ? DW1 : RW;
  localparam int unsigned DCW   = $clog2(DW + 1);
  localparam int unsigned CW    = RW + BCW + CNT_W + 4;      // threshold compare
  localparam int unsigned OTW   =
    ((1 + VW + chm_pkg::STAT_W + chm_pkg::ELEM_W + chm_pkg::BKT_W + 7) / 8) * 8;

  localparam logic [LW-1:0] EMPTY = LW'(NODE_COUNT);

  // --------------------------------------------------------------------------
  // sequencer states
  // --------------------------------------------------------------------------
  typedef enum logic [24:0] {
    S_INIT      = 25'h0000001,  // head sweep after reset
    S_IDLE      = 25'h0000002,
    S_HASH      = 25'h0000004,  // key mod bucket count
    S_HEAD      = 25'h0000008,
    S_HEAD_WT   = 25'h0000010,
    S_WALK      = 25'h0000020,
    S_WALK_WT   = 25'h0000040,
    S_ACT       = 25'h0000080,
    S_POP       = 25'h0000100,
    S_POP_WT    = 25'h0000200,
    S_CHK       = 25'h0000400,  // load thresholds
    S_IDEAL     = 25'h0000800,  // elements*16 / ideal
    S_PRIME     = 25'h0001000,
    S_PRIME_DIV = 25'h0002000,
    S_CLAMP     = 25'h0004000,
    S_RH_CLR    = 25'h0008000,  // empty the target bank
    S_RH_BKT    = 25'h0010000,
    S_RH_BWT    = 25'h0020000,
    S_RH_NODE   = 25'h0040000,
    S_RH_NWT    = 25'h0080000,
    S_RH_DIV    = 25'h0100000,
    S_RH_TO     = 25'h0200000,
    S_RH_TOWT   = 25'h0400000,
    S_CLR       = 25'h0800000,  // clear request, both banks
    S_DONE      = 25'h1000000
  } state_e;

  state_e state_q, state_d;

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  logic [chm_pkg::REQ_W-1:0]  req_q, req_d;
  logic [KW-1:0]              key_q, key_d;
  logic [VW-1:0]              val_q, val_d;
  logic                       found_q, found_d;
  logic [chm_pkg::STAT_W-1:0] status_q, status_d;
  logic [VW-1:0]              rd_q, rd_d;
  logic [BAW-1:0]             h_q, h_d;
  logic [LW-1:0]              head_q, head_d;
  logic [LW-1:0]              p_q, p_d;
  logic [LW-1:0]              prev_q, prev_d;
  logic [LW-1:0]              nx_q, nx_d;
  logic [CNT_W-1:0]           fc_q, fc_d;        // free stack fill
  logic [CNT_W-1:0]           mfc_q, mfc_d;      // lowest fill since clear
  logic [CNT_W-1:0]           stored_q, stored_d;
  logic [BCW-1:0]             active_q, active_d;
  logic                       bank_q, bank_d;
  logic [chm_pkg::INIT_W-1:0] init_q, init_d;
  logic [RW-1:0]              ideal_q, ideal_d;
  logic [RW-1:0]              lower_q, lower_d;
  logic [RW-1:0]              upper_q, upper_d;
  logic [HAW-1:0]             clr_idx_q, clr_idx_d;
  logic [BCW-1:0]             rb_q, rb_d;        // rehash source bucket
  logic [DW-1:0]              newn_q, newn_d;    // candidate bucket count
  logic [5:0]                 d_q, d_d;          // trial divisor

  // output register
  logic                       m_valid_q, m_valid_d;
  logic                       m_found_q, m_found_d;
  logic [VW-1:0]              m_rd_q, m_rd_d;
  logic [chm_pkg::STAT_W-1:0] m_status_q, m_status_d;
  logic [chm_pkg::ELEM_W-1:0] m_elem_q, m_elem_d;
  logic [chm_pkg::BKT_W-1:0]  m_bkt_q, m_bkt_d;

  // shared divider
  logic [DW-1:0]  div_rem_q, div_rem_d;
  logic [DW-1:0]  div_quo_q, div_quo_d;
  logic [DW-1:0]  div_dvs_q, div_dvs_d;
  logic [DCW-1:0] div_cnt_q, div_cnt_d;
  logic           div_start;
  logic [DW-1:0]  div_a, div_b;
  logic [DW:0]    div_trial, div_diff;
  logic           div_ge, div_done;

  // memory ports
  logic           head_we;
  logic [HAW-1:0] head_waddr, head_raddr;
  logic [LW-1:0]  head_wdata, head_rdata;
  logic           key_we, val_we, link_we;
  logic [NW-1:0]  node_waddr, node_raddr;
  logic [KW-1:0]  key_rdata;
  logic [VW-1:0]  val_rdata;
  logic [LW-1:0]  link_wdata, link_rdata;
  logic           stack_we;
  logic [NW-1:0]  stack_waddr, stack_raddr, stack_wdata, stack_rdata;

  // misc comb
  logic [chm_pkg::REQ_W-1:0] req_in;
  logic [KW-1:0]             key_in;
  logic [VW-1:0]             val_in;
  logic [CNT_W-1:0]          pop_pos;
  logic [NW-1:0]             pop_node;
  logic [RW-1:0]             thr;
  logic [CW-1:0]             prod, scaled;
  logic                      rehash_due;
  logic [DW-1:0]             newn_clamp;
  logic [chm_pkg::INIT_W-1:0] cfg_init;
  logic [BCW-1:0]            cfg_init_clamp;
  logic [31:0]               elem_w, bkt_w;

  assign req_in = s_axis_tuser;
  assign key_in = s_axis_tdata[KW-1:0];
  assign val_in = s_axis_tdata[KW+VW-1:KW];

  // --------------------------------------------------------------------------
  // shared restoring divider: one quotient bit per cycle
  // --------------------------------------------------------------------------
  assign div_trial = {div_rem_q, div_quo_q[DW-1]};
  assign div_diff  = div_trial - {1'b0, div_dvs_q};
  assign div_ge    = div_trial >= {1'b0, div_dvs_q};
  assign div_done  = (div_cnt_q == '0);

  always_comb begin
    div_rem_d = div_rem_q;
    div_quo_d = div_quo_q;
    div_dvs_d = div_dvs_q;
    div_cnt_d = div_cnt_q;
    if (div_start) begin
      div_rem_d = '0;
      div_quo_d = div_a;
      div_dvs_d = div_b;
      div_cnt_d = DCW'(DW);
    end else if (div_cnt_q != '0) begin
      div_rem_d = div_ge ? div_diff[DW-1:0] : div_trial[DW-1:0];
      div_quo_d = {div_quo_q[DW-2:0], div_ge};
      div_cnt_d = div_cnt_q - DCW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // datapath helpers
  // --------------------------------------------------------------------------
  // pop reads the stack top; an entry below the low mark was never written
  // since clear, so its own index is used in place of the RAM entry
  assign pop_pos  = fc_q - CNT_W'(1);
  assign pop_node = (pop_pos < mfc_q) ? pop_pos[NW-1:0] : stack_rdata;

  // ratio check: elements*16 against threshold*buckets
  assign thr    = (req_q == chm_pkg::REQ_PUT) ? upper_q : lower_q;
  assign prod   = CW'(thr) * CW'(active_q);
  assign scaled = CW'(stored_q) << 4;
  assign rehash_due = (req_q == chm_pkg::REQ_PUT) ?
                      ((upper_q > ideal_q) && (scaled > prod)) :
                      ((lower_q != '0) && (scaled < prod));

  assign newn_clamp = (newn_q > DW'(MAX_BUCKETS)) ? DW'(MAX_BUCKETS) : newn_q;

  // initial bucket count: zero reads as one, large values saturate
  assign cfg_init = cfg_data_i[chm_pkg::INIT_W-1:0];
  assign cfg_init_clamp = (cfg_init == '0) ? BCW'(1) :
                          (32'(cfg_init) > 32'(MAX_BUCKETS)) ? BCW'(MAX_BUCKETS) :
                          BCW'(cfg_init);

  assign elem_w = 32'(stored_q);
  assign bkt_w  = 32'(active_q);

  // head read address
  always_comb begin
    case (state_q)
      S_RH_BKT: head_raddr = {bank_q, rb_q[BAW-1:0]};
      S_RH_TO:  head_raddr = {~bank_q, h_q};
      default:  head_raddr = {bank_q, h_q};
    endcase
  end

  assign node_raddr  = p_q[NW-1:0];
  assign stack_raddr = pop_pos[NW-1:0];

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    key_d     = key_q;
    val_d     = val_q;
    found_d   = found_q;
    status_d  = status_q;
    rd_d      = rd_q;
    h_d       = h_q;
    head_d    = head_q;
    p_d       = p_q;
    prev_d    = prev_q;
    nx_d      = nx_q;
    fc_d      = fc_q;
    mfc_d     = mfc_q;
    stored_d  = stored_q;
    active_d  = active_q;
    bank_d    = bank_q;
    init_d    = init_q;
    ideal_d   = ideal_q;
    lower_d   = lower_q;
    upper_d   = upper_q;
    clr_idx_d = clr_idx_q;
    rb_d      = rb_q;
    newn_d    = newn_q;
    d_d       = d_q;

    m_valid_d  = m_valid_q & ~m_axis_tready;
    m_found_d  = m_found_q;
    m_rd_d     = m_rd_q;
    m_status_d = m_status_q;
    m_elem_d   = m_elem_q;
    m_bkt_d    = m_bkt_q;

    div_start = 1'b0;
    div_a     = key_q[KW-1:0] == '0 ? '0 : DW'(key_q);
    div_b     = DW'(active_q);

    head_we     = 1'b0;
    head_waddr  = {bank_q, h_q};
    head_wdata  = EMPTY;
    key_we      = 1'b0;
    val_we      = 1'b0;
    link_we     = 1'b0;
    node_waddr  = p_q[NW-1:0];
    link_wdata  = nx_q;
    stack_we    = 1'b0;
    stack_waddr = fc_q[NW-1:0];
    stack_wdata = p_q[NW-1:0];

    case (state_q)
      S_INIT: begin
        head_we    = 1'b1;
        head_waddr = clr_idx_q;
        clr_idx_d  = clr_idx_q + HAW'(1);
        if (&clr_idx_q) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (s_axis_tvalid) begin
          req_d    = req_in;
          key_d    = key_in;
          val_d    = val_in;
          found_d  = 1'b0;
          status_d = chm_pkg::ST_OK;
          rd_d     = '0;
          if (req_in == chm_pkg::REQ_CLEAR) begin
            clr_idx_d = '0;
            state_d   = S_CLR;
          end else if (req_in == chm_pkg::REQ_PUT && (key_in == '0 || val_in == '0)) begin
            status_d = chm_pkg::ST_BAD_ARG;
            state_d  = S_DONE;
          end else begin
            div_start = 1'b1;
            div_a     = DW'(key_in);
            div_b     = DW'(active_q);
            state_d   = S_HASH;
          end
        end
      end

      S_HASH: begin
        if (div_done) begin
          h_d     = div_rem_q[BAW-1:0];
          state_d = S_HEAD;
        end
      end

      S_HEAD: state_d = S_HEAD_WT;

      S_HEAD_WT: begin
        head_d  = head_rdata;
        p_d     = head_rdata;
        prev_d  = EMPTY;
        state_d = S_WALK;
      end

      S_WALK: begin
        state_d = (p_q < EMPTY) ? S_WALK_WT : S_ACT;
      end

      S_WALK_WT: begin
        nx_d = link_rdata;
        if (key_rdata == key_q) begin
          found_d = 1'b1;
          if (req_q == chm_pkg::REQ_GET) begin
            rd_d = val_rdata;
          end
          state_d = S_ACT;
        end else begin
          prev_d  = p_q;
          p_d     = link_rdata;
          state_d = S_WALK;
        end
      end

      S_ACT: begin
        state_d = S_DONE;
        case (req_q)
          chm_pkg::REQ_PUT: begin
            if (found_q) begin
              val_we     = 1'b1;
              node_waddr = p_q[NW-1:0];
            end else if (fc_q == '0) begin
              status_d = chm_pkg::ST_FULL;
            end else begin
              state_d = S_POP;
            end
          end
          chm_pkg::REQ_REMOVE: begin
            if (found_q) begin
              // unlink, then push the node back on the free stack
              if (prev_q < EMPTY) begin
                link_we    = 1'b1;
                node_waddr = prev_q[NW-1:0];
                link_wdata = nx_q;
              end else begin
                head_we    = 1'b1;
                head_waddr = {bank_q, h_q};
                head_wdata = nx_q;
              end
              if (fc_q < CNT_W'(NODE_COUNT)) begin
                stack_we = 1'b1;
                fc_d     = fc_q + CNT_W'(1);
              end
              if (stored_q != '0) begin
                stored_d = stored_q - CNT_W'(1);
              end
              state_d = S_CHK;
            end
          end
          default: ;
        endcase
      end

      S_POP: state_d = S_POP_WT;

      S_POP_WT: begin
        fc_d = pop_pos;
        if (pop_pos < mfc_q) begin
          mfc_d = pop_pos;
        end
        key_we     = 1'b1;
        val_we     = 1'b1;
        link_we    = 1'b1;
        node_waddr = pop_node;
        link_wdata = head_q;
        head_we    = 1'b1;
        head_waddr = {bank_q, h_q};
        head_wdata = LW'(pop_node);
        stored_d   = stored_q + CNT_W'(1);
        state_d    = S_CHK;
      end

      S_CHK: begin
        if (rehash_due) begin
          div_start = 1'b1;
          div_a     = DW'(stored_q) << 4;
          div_b     = (ideal_q == '0) ? DW'(1) : DW'(ideal_q);
          state_d   = S_IDEAL;
        end else begin
          state_d = S_DONE;
        end
      end

      S_IDEAL: begin
        if (div_done) begin
          newn_d  = (div_quo_q < DW'(chm_pkg::MIN_BUCKETS)) ?
                    DW'(chm_pkg::MIN_BUCKETS) : (div_quo_q | DW'(1));
          d_d     = chm_pkg::TRIAL_FIRST;
          state_d = S_PRIME;
        end
      end

      // step odd candidates until none of 3..49 below the candidate divides them
      S_PRIME: begin
        if (newn_q == DW'(d_q)) begin
          state_d = S_CLAMP;
        end else begin
          div_start = 1'b1;
          div_a     = newn_q;
          div_b     = DW'(d_q);
          state_d   = S_PRIME_DIV;
        end
      end

      S_PRIME_DIV: begin
        if (div_done) begin
          if (div_rem_q == '0) begin
            newn_d  = newn_q + DW'(2);
            d_d     = chm_pkg::TRIAL_FIRST;
            state_d = S_PRIME;
          end else if (d_q == chm_pkg::TRIAL_LAST) begin
            state_d = S_CLAMP;
          end else begin
            d_d     = d_q + 6'd2;
            state_d = S_PRIME;
          end
        end
      end

      S_CLAMP: begin
        if (BCW'(newn_clamp) == active_q) begin
          state_d = S_DONE;
        end else begin
          newn_d    = newn_clamp;
          clr_idx_d = '0;
          state_d   = S_RH_CLR;
        end
      end

      S_RH_CLR: begin
        head_we    = 1'b1;
        head_waddr = {~bank_q, clr_idx_q[BAW-1:0]};
        if (clr_idx_q[BAW-1:0] == BAW'(MAX_BUCKETS - 1)) begin
          clr_idx_d = '0;
          rb_d      = '0;
          state_d   = S_RH_BKT;
        end else begin
          clr_idx_d = clr_idx_q + HAW'(1);
        end
      end

      S_RH_BKT: begin
        if (rb_q == active_q) begin
          bank_d   = ~bank_q;
          active_d = BCW'(newn_q);
          state_d  = S_DONE;
        end else begin
          state_d = S_RH_BWT;
        end
      end

      S_RH_BWT: begin
        p_d     = head_rdata;
        rb_d    = rb_q + BCW'(1);
        state_d = S_RH_NODE;
      end

      S_RH_NODE: begin
        state_d = (p_q < EMPTY) ? S_RH_NWT : S_RH_BKT;
      end

      S_RH_NWT: begin
        nx_d      = link_rdata;
        div_start = 1'b1;
        div_a     = DW'(key_rdata);
        div_b     = newn_q;
        state_d   = S_RH_DIV;
      end

      S_RH_DIV: begin
        if (div_done) begin
          h_d     = div_rem_q[BAW-1:0];
          state_d = S_RH_TO;
        end
      end

      S_RH_TO: state_d = S_RH_TOWT;

      // push the node on the head of its new chain
      S_RH_TOWT: begin
        link_we    = 1'b1;
        node_waddr = p_q[NW-1:0];
        link_wdata = head_rdata;
        head_we    = 1'b1;
        head_waddr = {~bank_q, h_q};
        head_wdata = p_q;
        p_d        = nx_q;
        state_d    = S_RH_NODE;
      end

      S_CLR: begin
        head_we    = 1'b1;
        head_waddr = clr_idx_q;
        clr_idx_d  = clr_idx_q + HAW'(1);
        if (&clr_idx_q) begin
          fc_d     = CNT_W'(NODE_COUNT);
          mfc_d    = CNT_W'(NODE_COUNT);
          stored_d = '0;
          bank_d   = 1'b0;
          active_d = BCW'(chm_pkg::CLEAR_BUCKETS);
          state_d  = S_DONE;
        end
      end

      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_found_d  = found_q;
          m_rd_d     = rd_q;
          m_status_d = status_q;
          m_elem_d   = elem_w[chm_pkg::ELEM_W-1:0];
          m_bkt_d    = bkt_w[chm_pkg::BKT_W-1:0];
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // configuration writes must arrive only while idle; the block itself does not enforce it
    if (cfg_we_i) begin
      case (cfg_idx_i)
        chm_pkg::CFG_INIT: begin
          init_d = cfg_init;
          if (stored_q == '0) begin
            active_d = cfg_init_clamp;
          end
        end
        chm_pkg::CFG_IDEAL: ideal_d = cfg_data_i[RW-1:0];
        chm_pkg::CFG_LOWER: lower_d = cfg_data_i[RW-1:0];
        chm_pkg::CFG_UPPER: upper_d = cfg_data_i[RW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      fc_q      <= CNT_W'(NODE_COUNT);
      mfc_q     <= CNT_W'(NODE_COUNT);
      stored_q  <= '0;
      active_q  <= BCW'(chm_pkg::INIT_RST);
      bank_q    <= 1'b0;
      init_q    <= chm_pkg::INIT_RST;
      ideal_q   <= chm_pkg::IDEAL_RST;
      lower_q   <= chm_pkg::LOWER_RST;
      upper_q   <= chm_pkg::UPPER_RST;
      clr_idx_q <= '0;
      div_cnt_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fc_q      <= fc_d;
      mfc_q     <= mfc_d;
      stored_q  <= stored_d;
      active_q  <= active_d;
      bank_q    <= bank_d;
      init_q    <= init_d;
      ideal_q   <= ideal_d;
      lower_q   <= lower_d;
      upper_q   <= upper_d;
      clr_idx_q <= clr_idx_d;
      div_cnt_q <= div_cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    key_q      <= key_d;
    val_q      <= val_d;
    found_q    <= found_d;
    status_q   <= status_d;
    rd_q       <= rd_d;
    h_q        <= h_d;
    head_q     <= head_d;
    p_q        <= p_d;
    prev_q     <= prev_d;
    nx_q       <= nx_d;
    rb_q       <= rb_d;
    newn_q     <= newn_d;
    d_q        <= d_d;
    div_rem_q  <= div_rem_d;
    div_quo_q  <= div_quo_d;
    div_dvs_q  <= div_dvs_d;
    m_found_q  <= m_found_d;
    m_rd_q     <= m_rd_d;
    m_status_q <= m_status_d;
    m_elem_q   <= m_elem_d;
    m_bkt_q    <= m_bkt_d;
  end

  // --------------------------------------------------------------------------
  // memories
  // --------------------------------------------------------------------------
  chm_ram #(.WIDTH(LW), .DEPTH(HEAD_DEPTH)) u_heads (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (head_raddr),
    .rdata_o (head_rdata)
  );

  chm_ram #(.WIDTH(KW), .DEPTH(NODE_COUNT)) u_keys (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (node_waddr),
    .wdata_i (key_q),
    .raddr_i (node_raddr),
    .rdata_o (key_rdata)
  );

  chm_ram #(.WIDTH(VW), .DEPTH(NODE_COUNT)) u_values (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (node_waddr),
    .wdata_i (val_q),
    .raddr_i (node_raddr),
    .rdata_o (val_rdata)
  );

  chm_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_links (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (node_waddr),
    .wdata_i (link_wdata),
    .raddr_i (node_raddr),
    .rdata_o (link_rdata)
  );

  chm_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_free (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (stack_waddr),
    .wdata_i (stack_wdata),
    .raddr_i (stack_raddr),
    .rdata_o (stack_rdata)
  );

  // --------------------------------------------------------------------------
  // ports
  // --------------------------------------------------------------------------
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OTW'({m_bkt_q, m_elem_q, m_status_q, m_rd_q, m_found_q});

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `CHM_ASSERT(a_pool_sum, (CNT_W+1)'(fc_q) + (CNT_W+1)'(stored_q) == (CNT_W+1)'(NODE_COUNT), "free plus stored nodes differ from pool size")
  `CHM_ASSERT(a_low_mark, mfc_q <= fc_q, "free stack low mark above fill")
  `CHM_ASSERT(a_bkt_range, (active_q != '0) && (active_q <= BCW'(MAX_BUCKETS)), "bucket count out of range")
  `CHM_ASSERT_NXT(a_bank_flip, (state_q == S_RH_BKT) && (rb_q == active_q), bank_q != $past(bank_q), "rehash end did not switch bank")

endmodule
